// File: hw/rtl/i2c_light_sensor_reader_core_defines.svh
// ----------------------------------------------------------------------------
// I2C light sensor reader - assertion macros
// Concurrent assertion helpers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef I2C_LIGHT_SENSOR_READER_CORE_DEFINES_SVH
`define I2C_LIGHT_SENSOR_READER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CLSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CLSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/i2clsr_pkg.sv
// ----------------------------------------------------------------------------
// I2C light sensor reader - package
// Transaction types and fixed constants shared by the core's modules.
// ----------------------------------------------------------------------------
package i2clsr_pkg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] command_byte;
        logic       sda_sample;
    } t_in_item;

    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        sda_drive_enable;
        logic        busy_res;
        logic        done_res;
        logic        read_ok;
        logic [15:0] raw_count;
        logic [19:0] lux_q4;
    } t_out_item;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd35;
    localparam logic [3:0] BITS_PER_BYTE  = 4'd8;

    // lux = raw * 40 / 3 = 13 * raw + floor(raw / 3); raw / 3 by reciprocal.
    localparam logic [19:0] LUX_WHOLE_MUL = 20'd13;
    localparam logic [31:0] LUX_RECIP_3   = 32'd43691;
    localparam int          LUX_RECIP_SH  = 17;

endpackage

// File: hw/rtl/i2clsr_in_buf.sv
// ----------------------------------------------------------------------------
// I2C light sensor reader - input buffer
// Input register with a skid entry so that the stall toward the source
// comes straight from a flop.
// ----------------------------------------------------------------------------
module i2clsr_in_buf
    import i2clsr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_main_valid;
    logic     r_skid_valid;
    t_in_item r_main;
    t_in_item r_skid;
    logic     w_accept;

    assign w_accept = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_take) begin
                if (r_skid_valid) begin
                    r_main       <= r_skid;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_main_valid <= w_accept;
                    if (w_accept) begin
                        r_main <= i_item;
                    end
                end
            end else if (w_accept) begin
                if (!r_main_valid) begin
                    r_main_valid <= 1'b1;
                    r_main       <= i_item;
                end else begin
                    r_skid_valid <= 1'b1;
                    r_skid       <= i_item;
                end
            end
        end
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_item  = r_main;

endmodule

// File: hw/rtl/i2clsr_lux.sv
// ----------------------------------------------------------------------------
// I2C light sensor reader - lux conversion
// Converts the raw count to lux in Q4: floor(raw * 40 / 3).
// ----------------------------------------------------------------------------
module i2clsr_lux
    import i2clsr_pkg::*;
(
    input  logic [15:0] i_raw,
    output logic [19:0] o_lux_q4
);

    logic [31:0] w_recip_prod;
    logic [14:0] w_third;
    logic [19:0] w_whole;

    // The reciprocal product is exact for every 16-bit count.
    assign w_recip_prod = 32'(i_raw) * LUX_RECIP_3;
    assign w_third      = w_recip_prod[LUX_RECIP_SH +: 15];
    assign w_whole      = 20'(i_raw) * LUX_WHOLE_MUL;
    assign o_lux_q4     = w_whole + 20'(w_third);

endmodule

// File: hw/rtl/i2clsr_seq.sv
// ----------------------------------------------------------------------------
// I2C light sensor reader - bus sequencer
// Half-period slot sequencer for write and read transactions, with the
// result register that captures the pin levels and measurement.
// ----------------------------------------------------------------------------
module i2clsr_seq
    import i2clsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_item   i_item,
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data,
    output t_out_item  o_res
);

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_ADR_LO,
        PH_ADR_HI,
        PH_ADR_ACK_LO,
        PH_ADR_ACK_HI,
        PH_CMD_LO,
        PH_CMD_HI,
        PH_CMD_ACK_LO,
        PH_CMD_ACK_HI,
        PH_HIB_HI,
        PH_HIB_LO,
        PH_HIB_ACK_LO,
        PH_HIB_ACK_HI,
        PH_LOB_HI,
        PH_LOB_LO,
        PH_LOB_ACK_LO,
        PH_LOB_ACK_HI,
        PH_STOP_A,
        PH_STOP_B
    } t_phase;

    t_phase    r_phase,     n_phase;
    logic [3:0] r_bit_count, n_bit_count;
    logic [7:0] r_shift,     n_shift;
    logic [7:0] r_high,      n_high;
    logic      r_is_read,   n_is_read;
    logic [6:0] r_dev_addr;
    t_out_item r_res;
    t_out_item n_res;

    logic [3:0]  w_bc_inc;
    logic        w_done;
    logic        w_ok;
    logic        w_scl;
    logic        w_sda;
    logic        w_drv;
    logic [15:0] w_raw;
    logic [19:0] w_lux;

    assign w_bc_inc = r_bit_count + 4'd1;
    assign w_raw    = {r_high, r_shift};

    i2clsr_lux u_lux (
        .i_raw    (w_raw),
        .o_lux_q4 (w_lux)
    );

    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_high      = r_high;
        n_is_read   = r_is_read;
        w_done      = 1'b0;

        case (i_item.kind)
            KIND_WRITE, KIND_READ: begin
                // Commands are dropped while a transaction is running.
                if (r_phase == PH_IDLE) begin
                    n_is_read   = (i_item.kind == KIND_READ);
                    n_shift     = {r_dev_addr, i_item.kind[0]};
                    if (i_item.kind == KIND_WRITE) begin
                        n_high = i_item.command_byte;
                    end
                    n_bit_count = 4'd0;
                    n_phase     = PH_START_A;
                end
            end
            KIND_TICK: begin
                case (r_phase)
                    PH_START_A: n_phase = PH_START_B;
                    PH_START_B: begin
                        n_bit_count = 4'd0;
                        n_phase     = PH_ADR_LO;
                    end
                    PH_ADR_LO: n_phase = PH_ADR_HI;
                    PH_CMD_LO: n_phase = PH_CMD_HI;
                    PH_ADR_HI, PH_CMD_HI: begin
                        n_shift     = {r_shift[6:0], 1'b0};
                        n_bit_count = w_bc_inc;
                        if (w_bc_inc >= BITS_PER_BYTE) begin
                            n_phase = (r_phase == PH_ADR_HI) ? PH_ADR_ACK_LO : PH_CMD_ACK_LO;
                        end else begin
                            n_phase = (r_phase == PH_ADR_HI) ? PH_ADR_LO : PH_CMD_LO;
                        end
                    end
                    PH_ADR_ACK_LO: n_phase = PH_ADR_ACK_HI;
                    PH_ADR_ACK_HI: begin
                        n_bit_count = 4'd0;
                        if (r_is_read) begin
                            // A released data line here means no device answered.
                            if (i_item.sda_sample) begin
                                n_is_read = 1'b0;
                                n_phase   = PH_STOP_A;
                            end else begin
                                n_phase = PH_HIB_HI;
                            end
                        end else begin
                            n_shift = r_high;
                            n_phase = PH_CMD_LO;
                        end
                    end
                    PH_CMD_ACK_LO: n_phase = PH_CMD_ACK_HI;
                    PH_CMD_ACK_HI: n_phase = PH_STOP_A;
                    PH_HIB_HI, PH_LOB_HI: begin
                        n_shift     = {r_shift[6:0], i_item.sda_sample};
                        n_bit_count = w_bc_inc;
                        n_phase     = (r_phase == PH_HIB_HI) ? PH_HIB_LO : PH_LOB_LO;
                    end
                    PH_HIB_LO: begin
                        if (r_bit_count >= BITS_PER_BYTE) begin
                            n_high  = r_shift;
                            n_phase = PH_HIB_ACK_LO;
                        end else begin
                            n_phase = PH_HIB_HI;
                        end
                    end
                    PH_LOB_LO: begin
                        n_phase = (r_bit_count >= BITS_PER_BYTE) ? PH_LOB_ACK_LO : PH_LOB_HI;
                    end
                    PH_HIB_ACK_LO: n_phase = PH_HIB_ACK_HI;
                    PH_HIB_ACK_HI: begin
                        n_bit_count = 4'd0;
                        n_phase     = PH_LOB_HI;
                    end
                    PH_LOB_ACK_LO: n_phase = PH_LOB_ACK_HI;
                    PH_LOB_ACK_HI: n_phase = PH_STOP_A;
                    PH_STOP_A:     n_phase = PH_STOP_B;
                    PH_STOP_B: begin
                        n_phase = PH_IDLE;
                        w_done  = 1'b1;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            default: ;
        endcase
    end

    // Pin levels follow from the slot being driven after this step.
    always_comb begin
        case (n_phase)
            PH_START_B, PH_STOP_A, PH_HIB_ACK_HI: {w_scl, w_sda, w_drv} = 3'b101;
            PH_ADR_LO, PH_CMD_LO:                 {w_scl, w_sda, w_drv} = {1'b0, n_shift[7], 1'b1};
            PH_ADR_HI, PH_CMD_HI:                 {w_scl, w_sda, w_drv} = {1'b1, n_shift[7], 1'b1};
            PH_ADR_ACK_LO, PH_CMD_ACK_LO,
            PH_HIB_LO, PH_LOB_LO:                 {w_scl, w_sda, w_drv} = 3'b010;
            PH_ADR_ACK_HI, PH_CMD_ACK_HI,
            PH_HIB_HI, PH_LOB_HI:                 {w_scl, w_sda, w_drv} = 3'b110;
            PH_HIB_ACK_LO:                        {w_scl, w_sda, w_drv} = 3'b001;
            PH_LOB_ACK_LO:                        {w_scl, w_sda, w_drv} = 3'b011;
            default:                              {w_scl, w_sda, w_drv} = 3'b111;
        endcase
    end

    always_comb begin
        w_ok                   = w_done && r_is_read;
        n_res.scl_level        = w_scl;
        n_res.sda_level        = w_sda;
        n_res.sda_drive_enable = w_drv;
        n_res.busy_res         = (n_phase != PH_IDLE);
        n_res.done_res         = w_done;
        n_res.read_ok          = w_ok;
        n_res.raw_count        = w_ok ? w_raw : 16'd0;
        n_res.lux_q4           = w_ok ? w_lux : 20'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= 4'd0;
            r_shift     <= 8'd0;
            r_high      <= 8'd0;
            r_is_read   <= 1'b0;
            r_dev_addr  <= DEV_ADDR_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_dev_addr <= i_cfg_wr_data;
            end
            if (i_step) begin
                r_phase     <= n_phase;
                r_bit_count <= n_bit_count;
                r_shift     <= n_shift;
                r_high      <= n_high;
                r_is_read   <= n_is_read;
            end
        end
        if (i_step) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// File: hw/rtl/i2c_light_sensor_reader_core.sv
// ----------------------------------------------------------------------------
// I2C light sensor reader - top level
// Bit-level I2C master for an ambient light sensor, one half-period slot
// per tick transaction, with raw count and lux results on read completion.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      i_in_valid / o_in_stall    i_in_item  (t_in_item)
//   out       output     o_out_valid / i_out_stall  o_out_item (t_out_item)
//   cfg       input      i_cfg_wr_en                i_cfg_wr_data (address)
//
// Each transaction in produces one transaction out, registered in the input
// register and then in the result register. One transaction is accepted
// every cycle while o_in_stall is low. The slot sequencer steps once per
// transaction; the lux multiply sits in the same cycle ahead of the result
// register. A stalled output holds its result; the input keeps accepting
// until the input register and its skid entry are both full.
// Reset returns the sequencer to idle and the address to 35.
// ----------------------------------------------------------------------------
module i2c_light_sensor_reader_core
    import i2clsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data
);

    logic     w_buf_valid;
    t_in_item w_buf_item;
    logic     w_move;
    logic     r_out_valid;

    assign w_move = w_buf_valid && (!r_out_valid || !i_out_stall);

    i2clsr_in_buf u_in_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_take  (w_move),
        .o_valid (w_buf_valid),
        .o_item  (w_buf_item)
    );

    i2clsr_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_move),
        .i_item        (w_buf_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_res         (o_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/i2clsr_checker.sv
// ----------------------------------------------------------------------------
// I2C light sensor reader - port checker
// Checks result consistency rules and the output handshake at the top level.
// ----------------------------------------------------------------------------
`include "i2c_light_sensor_reader_core_defines.svh"

module i2clsr_checker
    import i2clsr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_item
);

    `I2CLSR_ASSERT_NEXT(a_valid_held, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid, "result valid dropped while stalled")
    `I2CLSR_ASSERT_NEXT(a_item_held, i_clk, i_rst_n, i_out_valid && i_out_stall, $stable(i_out_item), "result changed while stalled")
    `I2CLSR_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, i_out_valid && i_out_item.done_res, !i_out_item.busy_res && i_out_item.scl_level && i_out_item.sda_level, "finished transaction left the bus busy")
    `I2CLSR_ASSERT_NOW(a_ok_with_done, i_clk, i_rst_n, i_out_valid && (i_out_item.read_ok || i_out_item.raw_count != 16'd0 || i_out_item.lux_q4 != 20'd0), i_out_item.done_res && i_out_item.read_ok, "measurement reported outside a read completion")
    `I2CLSR_ASSERT_NOW(a_released_high, i_clk, i_rst_n, i_out_valid && !i_out_item.sda_drive_enable, i_out_item.sda_level && i_out_item.busy_res, "released data line not reading high")

endmodule

bind i2c_light_sensor_reader_core i2clsr_checker u_i2clsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);
